/* rtl/sorted_mac_table_core_defines.svh */
// Assertion macros used by the table controller RTL.
`ifndef SORTED_MAC_TABLE_CORE_DEFINES_SVH
`define SORTED_MAC_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SMT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("sorted mac table check failed");
`define SMT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sorted mac table check failed");
`else
`define SMT_ASSERT(lbl, clk, rst_n, prop)
`define SMT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/smt_pkg.sv */
package smt_pkg;

    localparam int KEY_W = 48;
    localparam int POS_W = 6;
    localparam int CNT_W = 7;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_GET    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   position;
        logic [KEY_W-1:0]   entry_mac;
    } t_result;

endpackage

/* rtl/smt_ram.sv */
module smt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/smt_ctrl.sv */
`include "sorted_mac_table_core_defines.svh"

module smt_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  smt_pkg::t_op                       i_op,
    input  logic [smt_pkg::KEY_W-1:0]          i_mac,
    input  logic [smt_pkg::POS_W-1:0]          i_index,
    input  logic [$clog2(DEPTH+1)-1:0]         i_cap,
    output logic [$clog2(DEPTH+1)-1:0]         o_count,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output smt_pkg::t_result                   o_res,
    output logic                               o_we,
    output logic [$clog2(DEPTH)-1:0]           o_waddr,
    output logic [smt_pkg::KEY_W-1:0]          o_wdata,
    output logic [$clog2(DEPTH)-1:0]           o_raddr,
    input  logic [smt_pkg::KEY_W-1:0]          i_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > smt_pkg::POS_W) ? CW : smt_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_MISS,
        S_SHRD,
        S_SHWR,
        S_GET,
        S_PUSH
    } t_state;

    t_state                       r_state;
    smt_pkg::t_op                 r_op;
    logic [smt_pkg::KEY_W-1:0]    r_mac;
    logic [smt_pkg::POS_W-1:0]    r_idx;
    logic [CW-1:0]                r_ptr;
    logic [AW-1:0]                r_sh;
    logic [CW-1:0]                r_count;
    smt_pkg::t_result             r_res;
    logic                         shift_done;

    assign shift_done = (CW'(r_sh) == r_ptr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op  <= i_op;
                        r_mac <= i_mac;
                        r_idx <= i_index;
                        r_ptr <= '0;
                        unique case (i_op)
                            smt_pkg::OP_CLEAR: begin
                                r_count <= '0;
                                r_res   <= '{smt_pkg::ST_OK, '0, '0};
                                r_state <= S_PUSH;
                            end
                            smt_pkg::OP_GET: begin
                                if (IW'(i_index) < IW'(r_count)) begin
                                    r_state <= S_GET;
                                end else begin
                                    r_res   <= '{smt_pkg::ST_MISS, i_index, '0};
                                    r_state <= S_PUSH;
                                end
                            end
                            smt_pkg::OP_INSERT: begin
                                if (r_count >= i_cap) begin
                                    r_res   <= '{smt_pkg::ST_FULL, '0, '0};
                                    r_state <= S_PUSH;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            smt_pkg::OP_SEARCH: begin
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // read of entry r_ptr is issued here; it goes unused if the scan ran off the end
                    if (r_ptr == r_count) begin
                        r_state <= S_MISS;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (i_rdata < r_mac) begin
                        r_ptr   <= r_ptr + 1'b1;
                        r_state <= S_SCAN;
                    end else if (i_rdata == r_mac) begin
                        r_res <= '{(r_op == smt_pkg::OP_INSERT) ? smt_pkg::ST_DUP
                                                                : smt_pkg::ST_OK,
                                   smt_pkg::POS_W'(r_ptr), r_mac};
                        r_state <= S_PUSH;
                    end else begin
                        r_state <= S_MISS;
                    end
                end
                S_MISS: begin
                    if (r_op == smt_pkg::OP_INSERT) begin
                        r_sh    <= AW'(r_count);
                        r_state <= S_SHRD;
                    end else begin
                        r_res   <= '{smt_pkg::ST_MISS, '0, '0};
                        r_state <= S_PUSH;
                    end
                end
                S_SHRD: begin
                    // at the insertion rank: drop the new key in and close out
                    if (shift_done) begin
                        r_count <= r_count + 1'b1;
                        r_res   <= '{smt_pkg::ST_OK, smt_pkg::POS_W'(r_ptr), r_mac};
                        r_state <= S_PUSH;
                    end else begin
                        r_state <= S_SHWR;
                    end
                end
                S_SHWR: begin
                    r_sh    <= r_sh - 1'b1;
                    r_state <= S_SHRD;
                end
                S_GET: begin
                    r_res   <= '{smt_pkg::ST_OK, r_idx, i_rdata};
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_raddr = '0;
        o_we    = 1'b0;
        o_waddr = r_sh;
        o_wdata = r_mac;
        case (r_state)
            S_IDLE: o_raddr = AW'(i_index);
            S_SCAN: o_raddr = AW'(r_ptr);
            S_SHRD: begin
                o_raddr = r_sh - 1'b1;
                o_we    = shift_done;
            end
            S_SHWR: begin
                o_we    = 1'b1;
                o_wdata = i_rdata;
            end
            default: o_raddr = '0;
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_PUSH);
    assign o_res       = r_res;
    assign o_count     = r_count;

    `SMT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `SMT_ASSERT(a_count_step, i_clk, i_rst_n, (r_count != $past(r_count)) |-> ((r_count == '0) || (r_count == $past(r_count) + 1'b1)))
    `SMT_ASSERT(a_write_only_insert, i_clk, i_rst_n, o_we |-> (r_op == smt_pkg::OP_INSERT))
    `SMT_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, (i_valid && o_ready) |=> (r_state != S_IDLE))
    `SMT_ASSERT(a_grow_on_insert, i_clk, i_rst_n, (r_count == $past(r_count) + 1'b1) |-> ($past(r_state) == S_SHRD))

endmodule

/* rtl/sorted_mac_table_core.sv */
// Sorted MAC table: keeps up to DEPTH unique 48-bit keys in ascending order.
// Input beats on the s_axis channel: tuser carries the operation (insert,
// search, get by rank, clear), tdata the key and the rank. Each beat gives
// exactly one result beat on m_axis with status, rank, key, count, full.
// Capacity is set through the cfg channel (0 means DEPTH); write it only
// while the block is idle. The cfg channel is always ready.
// Clear, a refused insert and a get past the count finish without touching
// the key memory; a get reads one entry; a search compares entries in rank
// order until it meets a key not below the one sought; an insert does the
// same scan and then moves each entry above the insertion rank up one place.
// All entry reads and writes go through the one read port and the one write
// port of the key memory.
// One operation is in flight at a time; s_axis_tready drops while it runs.
// A finished result sits in an output register, so the next beat is taken
// while the receiver stalls; a second result then waits until it drains.
// Reset empties the table and clears the capacity; no clearing pass needed.
module sorted_mac_table_core #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // mac[47:0], index[53:48], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // operation[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // position[5:0], entry_mac[53:6],
                                          // count[60:54], is_full[61], zero pad
    output logic [1:0]  o_m_axis_tuser,   // status[1:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data        // max_entries
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > smt_pkg::CNT_W) ? CW : smt_pkg::CNT_W;

    logic [smt_pkg::CNT_W-1:0]  r_max;
    logic [XW-1:0]              max_x;
    logic [CW-1:0]              cap;
    logic [CW-1:0]              count;
    logic                       full;

    logic                       res_valid;
    logic                       res_ready;
    smt_pkg::t_result           res;

    logic                       r_out_valid;
    smt_pkg::t_result           r_out;
    logic [smt_pkg::CNT_W-1:0]  r_out_count;
    logic                       r_out_full;

    logic                       we;
    logic [AW-1:0]              waddr;
    logic [smt_pkg::KEY_W-1:0]  wdata;
    logic [AW-1:0]              raddr;
    logic [smt_pkg::KEY_W-1:0]  rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

    // zero or anything above the built depth falls back to the depth
    assign max_x = XW'(r_max);
    assign cap   = ((r_max == '0) || (max_x > XW'(DEPTH))) ? CW'(DEPTH) : CW'(max_x);
    assign full  = (count >= cap);

    smt_ram #(
        .WIDTH (smt_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    smt_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (smt_pkg::t_op'(i_s_axis_tuser)),
        .i_mac       (i_s_axis_tdata[47:0]),
        .i_index     (i_s_axis_tdata[53:48]),
        .i_cap       (cap),
        .o_count     (count),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // count is already final when the result is handed over
    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out       <= res;
            r_out_count <= smt_pkg::CNT_W'(count);
            r_out_full  <= full;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {2'b00, r_out_full, r_out_count, r_out.entry_mac, r_out.position};

endmodule
